@@ sv/button_click_classifier_assert.svh @@
// Assertion macros shared by the classifier checker.
`ifndef BUTTON_CLICK_CLASSIFIER_ASSERT_SVH
`define BUTTON_CLICK_CLASSIFIER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BCC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("bcc assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define BCC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("bcc assertion failed");

`endif

@@ sv/bcc_pkg.sv @@
// Types and constants of the button click classifier.
`timescale 1ns / 1ps

package bcc_pkg;

  // Event codes on the result
  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_SHORT  = 2'd1,
    EV_LONG   = 2'd2,
    EV_DOUBLE = 2'd3
  } event_e;

  // Input item kinds
  typedef enum logic {
    KIND_POLL  = 1'b0,
    KIND_CLEAR = 1'b1
  } kind_e;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_LONG_PRESS = 2'd0,
    CFG_DOUBLE_GAP = 2'd1,
    CFG_DOUBLE_EN  = 2'd2,
    CFG_DEBOUNCE   = 2'd3
  } cfg_idx_e;

  localparam int unsigned CfgDataW = 16;
  localparam int unsigned InDataW  = 40;  // pressed + now_ms, padded to bytes
  localparam int unsigned OutDataW = 8;   // event_res, padded to a byte

  localparam logic [15:0] LongPressRst  = 16'd800;
  localparam logic [15:0] DoubleGapRst  = 16'd250;
  localparam logic        DoubleEnRst   = 1'b1;
  localparam logic [7:0]  DebounceRst   = 8'd20;

  typedef struct packed {
    logic [15:0] hold_time_ms;
    logic [15:0] dbl_window_ms;
    logic        double_enable;
    logic [7:0]  debounce_ms;
  } cfg_t;

  typedef struct packed {
    logic [31:0] press_stamp;
    logic [31:0] release_stamp;
    logic        held;
    logic        awaiting_second;
    logic        release_masked;
  } state_t;

endpackage

@@ sv/button_click_classifier.sv @@
// Top level of the button click classifier.
`timescale 1ns / 1ps

// Button click classifier: takes one poll or clear item per clock cycle while
// results are taken and gives exactly one event item for each (none, short,
// long, double). An item passes an input register, one classifier step and a
// result register; the state update of the single classifier step is
// combinational and is registered with the event, which sets the sustained
// rate of one item per cycle. The input side keeps accepting while a result
// waits, as long as the input register is empty. Configuration writes take
// effect on the next cycle and are meant for an idle block.
module button_click_classifier (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration write port
  input  logic                          cfg_we_i,
  input  logic [1:0]                    cfg_idx_i,
  input  logic [bcc_pkg::CfgDataW-1:0]  cfg_data_i,
  // input items
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [bcc_pkg::InDataW-1:0]   s_axis_tdata,  // [0] pressed, [32:1] now_ms
  input  logic [0:0]                    s_axis_tuser,  // [0] kind
  // result items
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [bcc_pkg::OutDataW-1:0]  m_axis_tdata   // [1:0] event_res
);

  bcc_pkg::cfg_t   cfg_q;
  bcc_pkg::state_t state_q, state_d;
  bcc_pkg::event_e event_d, event_q;

  logic            in_valid_q;
  bcc_pkg::kind_e  kind_q;
  logic            pressed_q;
  logic [31:0]     now_q;
  logic            out_valid_q;
  logic            advance;
  logic            fire;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.hold_time_ms  <= bcc_pkg::LongPressRst;
      cfg_q.dbl_window_ms <= bcc_pkg::DoubleGapRst;
      cfg_q.double_enable <= bcc_pkg::DoubleEnRst;
      cfg_q.debounce_ms   <= bcc_pkg::DebounceRst;
    end else if (cfg_we_i) begin
      unique case (bcc_pkg::cfg_idx_e'(cfg_idx_i))
        bcc_pkg::CFG_LONG_PRESS: cfg_q.hold_time_ms  <= cfg_data_i;
        bcc_pkg::CFG_DOUBLE_GAP: cfg_q.dbl_window_ms <= cfg_data_i;
        bcc_pkg::CFG_DOUBLE_EN:  cfg_q.double_enable <= cfg_data_i[0];
        bcc_pkg::CFG_DEBOUNCE:   cfg_q.debounce_ms   <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // Flow control: result register frees up when taken
  assign advance       = !out_valid_q || m_axis_tready;
  assign fire          = in_valid_q && advance;
  assign s_axis_tready = !in_valid_q || advance;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      kind_q    <= bcc_pkg::kind_e'(s_axis_tuser[0]);
      pressed_q <= s_axis_tdata[0];
      now_q     <= s_axis_tdata[32:1];
    end
  end

  // Classifier step
  bcc_core u_core (
    .cfg_i     (cfg_q),
    .state_i   (state_q),
    .kind_i    (kind_q),
    .pressed_i (pressed_q),
    .now_ms_i  (now_q),
    .state_o   (state_d),
    .event_o   (event_d)
  );

  // Classifier state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (fire) begin
      state_q <= state_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      event_q <= event_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(bcc_pkg::OutDataW-2){1'b0}}, event_q};

endmodule

@@ sv/bcc_core.sv @@
// Combinational classifier step: next state and event for one item.
`timescale 1ns / 1ps

module bcc_core (
  input  bcc_pkg::cfg_t   cfg_i,
  input  bcc_pkg::state_t state_i,
  input  bcc_pkg::kind_e  kind_i,
  input  logic            pressed_i,
  input  logic [31:0]     now_ms_i,
  output bcc_pkg::state_t state_o,
  output bcc_pkg::event_e event_o
);

  logic [31:0] press_span;
  logic [31:0] gap_span;

  // Elapsed times wrap modulo 2^32
  assign press_span = now_ms_i - state_i.press_stamp;
  assign gap_span   = now_ms_i - state_i.release_stamp;

  always_comb begin
    state_o = state_i;
    event_o = bcc_pkg::EV_NONE;
    if (kind_i == bcc_pkg::KIND_CLEAR) begin
      // clear item drops the flags, stamps kept
      state_o.held            = 1'b0;
      state_o.awaiting_second = 1'b0;
      state_o.release_masked  = 1'b0;
    end else if (pressed_i && !state_i.held) begin
      // press edge
      state_o.held           = 1'b1;
      state_o.press_stamp    = now_ms_i;
      state_o.release_masked = 1'b0;
      if (cfg_i.double_enable && state_i.awaiting_second) begin
        state_o.awaiting_second = 1'b0;
        state_o.release_masked  = 1'b1;
        event_o                 = bcc_pkg::EV_DOUBLE;
      end
    end else if (!pressed_i && state_i.held) begin
      // release edge
      state_o.held = 1'b0;
      if (!state_i.release_masked && (press_span > {24'd0, cfg_i.debounce_ms})) begin
        if (cfg_i.double_enable) begin
          state_o.awaiting_second = 1'b1;
          state_o.release_stamp   = now_ms_i;
        end else begin
          event_o = bcc_pkg::EV_SHORT;
        end
      end
    end else if (pressed_i) begin
      // still held: long press fires once
      if (!state_i.release_masked && (press_span > {16'd0, cfg_i.hold_time_ms})) begin
        state_o.release_masked  = 1'b1;
        state_o.awaiting_second = 1'b0;
        event_o                 = bcc_pkg::EV_LONG;
      end
    end else begin
      // still released: window expiry
      if (cfg_i.double_enable && state_i.awaiting_second &&
          (gap_span > {16'd0, cfg_i.dbl_window_ms})) begin
        state_o.awaiting_second = 1'b0;
        event_o                 = bcc_pkg::EV_SHORT;
      end
    end
  end

endmodule

@@ sv/bcc_checker.sv @@
// Port-level checker for the button click classifier, bound to the top level.
`timescale 1ns / 1ps
`include "button_click_classifier_assert.svh"

module bcc_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         s_axis_tready,
  input logic                         m_axis_tvalid,
  input logic                         m_axis_tready,
  input logic [bcc_pkg::OutDataW-1:0] m_axis_tdata
);

  // a stalled result holds
  `BCC_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

  // padding above the event code stays zero
  `BCC_ASSERT_NOW(a_out_pad, m_axis_tvalid, m_axis_tdata[bcc_pkg::OutDataW-1:2] == '0)

  // input only stalls when a result is waiting and not taken
  `BCC_ASSERT_NOW(a_in_stall, !s_axis_tready, m_axis_tvalid && !m_axis_tready)

endmodule

bind button_click_classifier bcc_checker u_bcc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
